>>> rtl/core/bce_pkg.sv
// Package for the binary cross-entropy loss/gradient unit.
// Types, constants and command/status structs shared by ctrl, datapath and top.
package bce_pkg;

    localparam int DEF_MAX_SAMPLES = 1024;
    localparam int DEF_MAX_CLASSES = 1024;
    localparam int CNT_W  = 11;
    localparam int P_W    = 31;
    localparam int GRAD_W = 48;
    localparam int LOSS_W = 32;
    localparam int SUM_W  = 48;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [30:0] EPS_Q30 = 31'd107;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam int LOG_FRAC = 28;

    localparam logic [1:0] REG_SAMPLES = 2'd0;
    localparam logic [1:0] REG_CLASSES = 2'd1;
    localparam logic [1:0] REG_WEIGHT  = 2'd2;

    typedef struct packed {
        logic [30:0] probability;
        logic [30:0] target;
        logic        final_element;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] gradient;
        logic [31:0]        batch_loss;
        logic               loss_valid;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_MUL, ST_LOGNORM, ST_LOG, ST_LOGMUL, ST_ELEM,
        ST_DIV, ST_MEAN, ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic mul;
        logic lognorm;
        logic logstep;
        logic logmul;
        logic elem;
        logic divstep;
        logic meanstep;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic log_last;
        logic div_last;
        logic mean_last;
        logic is_final;
    } stat_t;

endpackage

>>> rtl/core/bce_ctrl.sv
// Sequencer for the loss/gradient unit.
// Depends on bce_pkg; drives command strobes into bce_datapath.
module bce_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic          out_free,
    input  bce_pkg::stat_t stat,
    output bce_pkg::cmd_t  cmd,
    output logic          busy
);
    import bce_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_fire) state_next = ST_PREP;
            ST_PREP:    state_next = ST_MUL;
            ST_MUL:     state_next = ST_LOGNORM;
            ST_LOGNORM: state_next = ST_LOG;
            ST_LOG:     if (stat.log_last) state_next = ST_LOGMUL;
            ST_LOGMUL:  state_next = ST_ELEM;
            ST_ELEM:    state_next = ST_DIV;
            ST_DIV:     if (stat.div_last) state_next = stat.is_final ? ST_MEAN : ST_DONE;
            ST_MEAN:    if (stat.mean_last) state_next = ST_DONE;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.load     = in_fire;
        cmd.prep     = (state_reg == ST_PREP);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.lognorm  = (state_reg == ST_LOGNORM);
        cmd.logstep  = (state_reg == ST_LOG);
        cmd.logmul   = (state_reg == ST_LOGMUL);
        cmd.elem     = (state_reg == ST_ELEM);
        cmd.divstep  = (state_reg == ST_DIV);
        cmd.meanstep = (state_reg == ST_MEAN);
        cmd.finish   = (state_reg == ST_DONE) && out_free;
        busy         = (state_reg != ST_IDLE);
    end
endmodule

>>> rtl/core/bce_datapath.sv
// Datapath: clamps, multiplier products, bit-serial log2 for two
// operands, restoring divider for gradient and mean. Depends on bce_pkg.
module bce_datapath #(
    parameter int MAX_SAMPLES = bce_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_CLASSES = bce_pkg::DEF_MAX_CLASSES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bce_pkg::cmd_t     cmd,
    input  bce_pkg::in_item_t in_item,
    input  logic [10:0]       num_samples,
    input  logic [10:0]       num_classes,
    input  logic [31:0]       grad_scale,
    output bce_pkg::stat_t    stat,
    output bce_pkg::out_item_t result
);
    import bce_pkg::*;

    // widest numerator: 31+32+34 bits; quotient kept at 97 bits
    localparam int NUM_W = 97;
    localparam int DEN_W = 84;

    logic [30:0] p_reg, y_reg, pc_reg, qc_reg, n_reg;
    logic        fin_reg, neg_n_reg, neg_w_reg;
    logic [31:0] w_reg;
    logic [10:0] b_reg, c_reg;
    logic [61:0] pq_reg;
    logic [21:0] bc_reg;
    logic [62:0] nw_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] num_reg, quo_reg;
    logic [DEN_W:0]   rem_reg;
    logic [6:0]  dcnt_reg;
    logic [31:0] ma_reg, mb_reg;          // normalized mantissas Q1.30 (<2^31)
    logic [4:0]  ea_reg, eb_reg;
    logic [27:0] fa_reg, fb_reg;
    logic [4:0]  lcnt_reg;
    logic [60:0] nla_reg, nlb_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [47:0] mnum_reg;
    logic [47:0] mq_reg;
    logic [19:0] mden_reg;
    logic [20:0] mrem_reg;
    logic [5:0]  mcnt_reg;
    out_item_t   res_reg;

    function automatic logic [10:0] clamp_cnt(input logic [10:0] v, input int maxv);
        logic [10:0] r;
        r = v;
        if (v == '0) r = 11'd1;
        else if (32'(v) > maxv) r = 11'(maxv);
        return r;
    endfunction

    function automatic logic [4:0] msb_pos(input logic [30:0] x);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < 31; i++)
            if (x[i]) r = 5'(i);
        return r;
    endfunction

    logic [30:0] p_sat, y_sat, qraw;
    logic [32:0] sq_a, sq_b;
    logic [63:0] sqa_full, sqb_full;
    logic [DEN_W:0] rem_sh;
    logic [20:0] mrem_sh;
    logic [48:0] sum_add;
    logic [88:0] elem_sum;
    logic [30:0] pq_half;
    logic [52:0] den_part;

    always_comb
    begin
        p_sat = (in_item.probability > ONE_Q30) ? ONE_Q30 : in_item.probability;
        y_sat = (in_item.target > ONE_Q30) ? ONE_Q30 : in_item.target;
        qraw  = ONE_Q30 - p_reg;
        sqa_full = 64'(ma_reg) * 64'(ma_reg);
        sqb_full = 64'(mb_reg) * 64'(mb_reg);
        sq_a = 33'(sqa_full >> 30);
        sq_b = 33'(sqb_full >> 30);
        rem_sh  = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
        mrem_sh = {mrem_reg[19:0], mnum_reg[47]};
        elem_sum = 89'(nla_reg) + 89'(nlb_reg);
        sum_add = 49'(sum_reg) + 49'(elem_sum >> 30);
        // denominator in two halves: low half of p*q first, high half next
        pq_half  = cmd.lognorm ? pq_reg[30:0] : pq_reg[61:31];
        den_part = 53'(pq_half) * 53'(bc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg   <= p_sat;
            y_reg   <= y_sat;
            fin_reg <= in_item.final_element;
            b_reg   <= clamp_cnt(num_samples, MAX_SAMPLES);
            c_reg   <= clamp_cnt(num_classes, MAX_CLASSES);
            neg_w_reg <= grad_scale[31];
            w_reg   <= grad_scale[31] ? (32'd0 - grad_scale) : grad_scale;
        end
        if (cmd.prep)
        begin
            pc_reg <= (p_reg < EPS_Q30) ? EPS_Q30 : p_reg;
            qc_reg <= (qraw < EPS_Q30) ? EPS_Q30 : qraw;
            bc_reg <= 22'(b_reg) * 22'(c_reg);
        end
        if (cmd.mul)
        begin
            pq_reg    <= 62'(pc_reg) * 62'(qc_reg);
            neg_n_reg <= pc_reg < y_reg;
            n_reg     <= (pc_reg < y_reg) ? (y_reg - pc_reg) : (pc_reg - y_reg);
        end
        if (cmd.lognorm)
        begin
            nw_reg <= 63'(n_reg) * 63'(w_reg);
            den_reg <= DEN_W'(den_part);
            ea_reg <= msb_pos(pc_reg);
            eb_reg <= msb_pos(qc_reg);
            ma_reg <= 32'(pc_reg) << (5'd30 - msb_pos(pc_reg));
            mb_reg <= 32'(qc_reg) << (5'd30 - msb_pos(qc_reg));
            fa_reg <= '0;
            fb_reg <= '0;
            lcnt_reg <= '0;
        end
        if (cmd.logstep)
        begin
            // one fraction bit per cycle for both logs
            ma_reg <= sq_a[31] ? 32'(sq_a >> 1) : 32'(sq_a);
            mb_reg <= sq_b[31] ? 32'(sq_b >> 1) : 32'(sq_b);
            fa_reg <= {fa_reg[26:0], sq_a[31]};
            fb_reg <= {fb_reg[26:0], sq_b[31]};
            lcnt_reg <= lcnt_reg + 5'd1;
            num_reg <= NUM_W'(nw_reg) << 34;
            rem_reg <= '0;
            quo_reg <= '0;
            dcnt_reg <= '0;
            if (lcnt_reg == 5'd0)
                den_reg <= den_reg + (DEN_W'(den_part) << 31);
        end
        if (cmd.logmul)
        begin
            nla_reg <= 61'((64'((33'd30 << LOG_FRAC) - {ea_reg, fa_reg})
                       * 64'(LN2_Q30)) >> 34);
            nlb_reg <= 61'((64'((33'd30 << LOG_FRAC) - {eb_reg, fb_reg})
                       * 64'(LN2_Q30)) >> 34);
        end
        if (cmd.elem)
        begin
            nla_reg <= 61'(nla_reg[30:0]) * 61'(y_reg);
            nlb_reg <= 61'(nlb_reg[30:0]) * 61'(ONE_Q30 - y_reg);
        end
        if (cmd.divstep)
        begin
            num_reg  <= num_reg << 1;
            dcnt_reg <= dcnt_reg + 7'd1;
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
            if (dcnt_reg == 7'd0)
            begin
                mnum_reg <= sum_add[48] ? {SUM_W{1'b1}} : sum_add[47:0];
                mden_reg <= 20'(b_reg) << 8;
                mrem_reg <= '0;
                mq_reg   <= '0;
                mcnt_reg <= '0;
            end
        end
        if (cmd.meanstep)
        begin
            mnum_reg <= mnum_reg << 1;
            mcnt_reg <= mcnt_reg + 6'd1;
            if (mrem_sh >= {1'b0, mden_reg})
            begin
                mrem_reg <= mrem_sh - {1'b0, mden_reg};
                mq_reg   <= {mq_reg[46:0], 1'b1};
            end
            else
            begin
                mrem_reg <= mrem_sh;
                mq_reg   <= {mq_reg[46:0], 1'b0};
            end
        end
    end

    // accumulator: update on the first divide step, clear on the final element
    logic div_first;
    assign div_first = cmd.divstep && (dcnt_reg == 7'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (div_first)
            sum_reg <= fin_reg ? '0 : (sum_add[48] ? {SUM_W{1'b1}} : sum_add[47:0]);
    end

    logic [47:0] grad_mag;
    logic        grad_neg;
    logic [47:0] lim;
    always_comb
    begin
        grad_neg = neg_n_reg ^ neg_w_reg;
        lim = grad_neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        grad_mag = (quo_reg[NUM_W-1:48] != '0 || quo_reg[47:0] > lim) ? lim
                   : quo_reg[47:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.divstep && dcnt_reg == 7'(NUM_W))
        begin
            res_reg.gradient   <= grad_neg ? (48'd0 - grad_mag) : grad_mag;
            res_reg.batch_loss <= '0;
            res_reg.loss_valid <= 1'b0;
        end
        if (cmd.meanstep && mcnt_reg == 6'd48)
        begin
            res_reg.batch_loss <= (mq_reg[47:32] != '0) ? 32'hFFFF_FFFF : mq_reg[31:0];
            res_reg.loss_valid <= 1'b1;
        end
    end

    // divider: the last step (dcnt_reg == NUM_W) latches the gradient
    assign stat.log_last  = (lcnt_reg == 5'(LOG_FRAC - 1));
    assign stat.div_last  = (dcnt_reg == 7'(NUM_W));
    assign stat.mean_last = (mcnt_reg == 6'd48);
    assign stat.is_final  = fin_reg;
    assign result = res_reg;
endmodule

>>> rtl/core/binary_cross_entropy_loss_grad_unit.sv
// Binary cross-entropy loss and gradient unit, one element at a time.
// Steps per accepted element: 3 setup, 28 log2 steps, 2 loss steps, 98 divider
// steps, 49 mean-divider steps on a final element only, then the output load,
// which waits while the previous result still waits at the output. A new
// element is accepted only when the unit is idle again, after that load.
// Reset: async active low; registers return to B=1, C=1, weight 1.0, sum 0.
module binary_cross_entropy_loss_grad_unit #(
    parameter int MAX_SAMPLES = bce_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_CLASSES = bce_pkg::DEF_MAX_CLASSES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bce_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bce_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  bce_pkg::cfg_item_t  cfg_data
);
    import bce_pkg::*;

    logic [10:0] samples_reg, classes_reg;
    logic [31:0] weight_reg;
    logic        oval_reg;
    out_item_t   obuf_reg;
    cmd_t        cmd;
    stat_t       stat;
    out_item_t   dp_result;
    logic        busy, in_fire, out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !oval_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg <= 11'd1;
            classes_reg <= 11'd1;
            weight_reg  <= 32'd65536;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_data.index)
                REG_SAMPLES: samples_reg <= cfg_data.data[10:0];
                REG_CLASSES: classes_reg <= cfg_data.data[10:0];
                REG_WEIGHT:  weight_reg  <= cfg_data.data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            oval_reg <= 1'b0;
        else if (cmd.finish)
            oval_reg <= 1'b1;
        else if (out_ready)
            oval_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            obuf_reg <= dp_result;
    end

    assign out_valid = oval_reg;
    assign out_data  = obuf_reg;

    bce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    bce_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_item     (in_data),
        .num_samples (samples_reg),
        .num_classes (classes_reg),
        .grad_scale  (weight_reg),
        .stat        (stat),
        .result      (dp_result)
    );
endmodule
